@@ rtl/utf8_decode_display_width_top_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODE_DISPLAY_WIDTH_TOP_ASSERT_SVH
`define UTF8_DECODE_DISPLAY_WIDTH_TOP_ASSERT_SVH

// same-cycle implication
`define UDW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/utf8dw_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Word types, byte class codes, width tables and the column width lookup.
// ----------------------------------------------------------------------------
package utf8dw_pkg;

    localparam int UDW_SUM_BITS = 16;
    localparam int CP_BITS      = 21;
    localparam int RW_BITS      = 16;
    localparam logic [RW_BITS-1:0] RW_MAX = 16'hFFFF;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] BITS2_MASK = 8'h1F;
    localparam logic [7:0] BITS3_MASK = 8'h0F;
    localparam logic [7:0] BITS4_MASK = 8'h07;

    localparam logic [1:0] COLS_ZERO = 2'd0;
    localparam logic [1:0] COLS_ONE  = 2'd1;
    localparam logic [1:0] COLS_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [CP_BITS-1:0] code_point;
        logic               invalid;
        logic [2:0]         byte_count;
        logic [1:0]         char_width;
        logic [RW_BITS-1:0] running_width;
        logic               text_done;
    } out_word_t;

    typedef struct packed {
        logic [1:0]         bad_left;
        logic               tail_valid;
        logic               tail_bad;
        logic [CP_BITS-1:0] tail_cp;
        logic [2:0]         tail_count;
        logic               eot;
    } job_t;

    localparam int ZERO_N = 5;
    localparam logic [CP_BITS-1:0] ZERO_LO [ZERO_N] = '{
        21'h00300, 21'h0200B, 21'h0FE00, 21'h0FEFF, 21'h1F3FB
    };
    localparam logic [CP_BITS-1:0] ZERO_HI [ZERO_N] = '{
        21'h0036F, 21'h0200F, 21'h0FE0F, 21'h0FEFF, 21'h1F3FF
    };

    localparam int TWO_N = 36;
    localparam logic [CP_BITS-1:0] TWO_LO [TWO_N] = '{
        21'h01100, 21'h02329, 21'h02460, 21'h02E80, 21'h03041, 21'h03400,
        21'h04E00, 21'h0A000, 21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30,
        21'h0FF00, 21'h0FFE0, 21'h1F300, 21'h1F900, 21'h20000, 21'h30000,
        21'h000B7, 21'h02010, 21'h02018, 21'h0201C, 21'h02020, 21'h02030,
        21'h02032, 21'h02035, 21'h0203B, 21'h0203E, 21'h02160, 21'h02190,
        21'h02260, 21'h02264, 21'h025A0, 21'h02605, 21'h02714, 21'h02718
    };
    localparam logic [CP_BITS-1:0] TWO_HI [TWO_N] = '{
        21'h0115F, 21'h0232A, 21'h024FF, 21'h0303E, 21'h033FF, 21'h04DBF,
        21'h09FFF, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF, 21'h0FE19, 21'h0FE6F,
        21'h0FF60, 21'h0FFE6, 21'h1F64F, 21'h1F9FF, 21'h2FFFD, 21'h3FFFD,
        21'h000B7, 21'h02016, 21'h02019, 21'h0201D, 21'h02027, 21'h02030,
        21'h02033, 21'h02035, 21'h0203B, 21'h0203E, 21'h02179, 21'h02199,
        21'h02260, 21'h02265, 21'h025FF, 21'h02606, 21'h02714, 21'h02718
    };

    function automatic logic [1:0] char_cols(input logic [CP_BITS-1:0] cp);
        logic [1:0] cols;
        logic       hit_two;
        logic       hit_zero;
        hit_two  = 1'b0;
        hit_zero = 1'b0;
        for (int k = 0; k < TWO_N; k++) begin
            if (cp >= TWO_LO[k] && cp <= TWO_HI[k]) hit_two = 1'b1;
        end
        for (int k = 0; k < ZERO_N; k++) begin
            if (cp >= ZERO_LO[k] && cp <= ZERO_HI[k]) hit_zero = 1'b1;
        end
        cols = hit_zero ? COLS_ZERO : (hit_two ? COLS_TWO : COLS_ONE);
        return cols;
    endfunction

endpackage

@@ rtl/utf8dw_emit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder result stage
// Holds one decoded job, sends its characters through the result register
// one per cycle unless stalled; keeps the saturating running column sum.
// ----------------------------------------------------------------------------
module utf8dw_emit
    import utf8dw_pkg::*;
#(
    parameter int SUM_BITS = UDW_SUM_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  job_t      job_in,
    output logic      job_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int WIDE_BITS = (SUM_BITS > RW_BITS) ? SUM_BITS : RW_BITS;

    job_t                job_reg, job_next;
    logic                job_valid_reg, job_valid_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic                m_valid_reg, m_valid_next;
    out_word_t           m_data_reg, m_data_next;

    logic                 fire;
    logic                 last;
    logic                 cur_bad;
    logic [1:0]           cur_w;
    logic [SUM_BITS:0]    sum_add;
    logic [SUM_BITS-1:0]  sum_sat;
    logic [WIDE_BITS-1:0] sum_wide;

    assign fire      = job_valid_reg && (!m_valid_reg || m_ready);
    assign last      = (job_reg.bad_left == 2'd0) ||
                       (job_reg.bad_left == 2'd1 && !job_reg.tail_valid);
    assign job_ready = !job_valid_reg || (fire && last);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        cur_bad  = (job_reg.bad_left != 2'd0) || job_reg.tail_bad;
        cur_w    = cur_bad ? COLS_ONE : char_cols(job_reg.tail_cp);
        sum_add  = {1'b0, sum_reg} + (SUM_BITS+1)'(cur_w);
        sum_sat  = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
        sum_wide = WIDE_BITS'(sum_sat);

        m_data_next.code_point    = cur_bad ? '0 : job_reg.tail_cp;
        m_data_next.invalid       = cur_bad;
        m_data_next.byte_count    = cur_bad ? 3'd1 : job_reg.tail_count;
        m_data_next.char_width    = cur_w;
        m_data_next.running_width = (sum_wide > WIDE_BITS'(RW_MAX)) ? RW_MAX
                                                                    : sum_wide[RW_BITS-1:0];
        m_data_next.text_done     = last && job_reg.eot;
    end

    always_comb begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        sum_next       = sum_reg;
        m_valid_next   = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            sum_next     = (last && job_reg.eot) ? '0 : sum_sat;
            if (last) begin
                job_valid_next = 1'b0;
            end else begin
                job_next.bad_left = job_reg.bad_left - 2'd1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            job_next       = job_in;
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            sum_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            sum_reg       <= sum_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

`include "utf8_decode_display_width_top_assert.svh"

    `UDW_ASSERT_NOW(a_load_when_free, load, job_ready, "job loaded while stage busy")
    `UDW_ASSERT_NOW(a_tail_pending, job_valid_reg && job_reg.bad_left == 2'd0,
                    job_reg.tail_valid, "job holds no character")
    `UDW_ASSERT_NEXT(a_sum_clear, fire && last && job_reg.eot, sum_reg == '0,
                     "column sum not cleared after end of text")
    `UDW_ASSERT_NEXT(a_fire_shows, fire, m_valid_reg, "sent word not shown")

endmodule

@@ rtl/utf8_decode_display_width_top.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder with display column width
// Decodes a byte stream into characters with code point, width and running
// text width; malformed input yields invalid characters.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while s_ready is high. A byte that ends a
// character or breaks a sequence is decoded at acceptance and its characters
// leave through one result register, one word per cycle unless stalled. A
// byte that yields k characters (up to 4, after a broken sequence) holds
// s_ready low until its last character is sent, as the stage holds a single
// job; bytes that only open or extend a sequence yield no word.
// ----------------------------------------------------------------------------
module utf8_decode_display_width_top
    import utf8dw_pkg::*;
#(
    parameter int SUM_BITS = UDW_SUM_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic [CP_BITS-1:0] partial_reg, partial_next;
    logic [1:0]         expect_reg, expect_next;
    logic [1:0]         seen_reg, seen_next;

    logic [7:0]         b;
    logic               eot;
    logic               accept;
    logic               has_result;
    logic               lead_go;
    logic               lead_ascii;
    logic [1:0]         lead_need;
    logic [CP_BITS-1:0] lead_bits;
    logic [CP_BITS-1:0] ext_cp;
    logic [1:0]         seen_inc;
    job_t               job;

    assign b      = s_data.data_byte;
    assign eot    = s_data.end_of_text;
    assign accept = s_valid && s_ready;

    always_comb begin
        lead_ascii = !b[7];
        lead_need  = 2'd0;
        lead_bits  = '0;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            lead_need = 2'd1;
            lead_bits = CP_BITS'(b & BITS2_MASK);
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            lead_need = 2'd2;
            lead_bits = CP_BITS'(b & BITS3_MASK);
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            lead_need = 2'd3;
            lead_bits = CP_BITS'(b & BITS4_MASK);
        end
    end

    always_comb begin
        job          = '0;
        job.eot      = eot;
        partial_next = partial_reg;
        expect_next  = expect_reg;
        seen_next    = seen_reg;
        lead_go      = 1'b0;
        ext_cp       = {partial_reg[CP_BITS-7:0], b[5:0]};
        seen_inc     = seen_reg + 2'd1;

        if (expect_reg != 2'd0) begin
            if ((b & CONT_MASK) == CONT_CODE) begin
                if (seen_inc >= expect_reg) begin
                    job.tail_valid = 1'b1;
                    job.tail_cp    = ext_cp;
                    job.tail_count = {1'b0, expect_reg} + 3'd1;
                    partial_next   = '0;
                    expect_next    = 2'd0;
                    seen_next      = 2'd0;
                end else if (eot) begin
                    job.bad_left = seen_inc + 2'd1;
                end else begin
                    partial_next = ext_cp;
                    seen_next    = seen_inc;
                end
            end else begin
                job.bad_left = seen_reg + 2'd1;
                partial_next = '0;
                expect_next  = 2'd0;
                seen_next    = 2'd0;
                lead_go      = 1'b1;
            end
        end else begin
            lead_go = 1'b1;
        end

        if (lead_go) begin
            if (lead_ascii) begin
                job.tail_valid = 1'b1;
                job.tail_cp    = CP_BITS'(b);
                job.tail_count = 3'd1;
            end else if (lead_need != 2'd0 && !eot) begin
                partial_next = lead_bits;
                expect_next  = lead_need;
                seen_next    = 2'd0;
            end else begin
                job.tail_valid = 1'b1;
                job.tail_bad   = 1'b1;
                job.tail_count = 3'd1;
            end
        end

        if (eot) begin
            partial_next = '0;
            expect_next  = 2'd0;
            seen_next    = 2'd0;
        end

        has_result = (job.bad_left != 2'd0) || job.tail_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            expect_reg  <= 2'd0;
            seen_reg    <= 2'd0;
        end else if (accept) begin
            partial_reg <= partial_next;
            expect_reg  <= expect_next;
            seen_reg    <= seen_next;
        end
    end

    utf8dw_emit #(
        .SUM_BITS (SUM_BITS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && has_result),
        .job_in    (job),
        .job_ready (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`include "utf8_decode_display_width_top_assert.svh"

    `UDW_ASSERT_NOW(a_seen_below, expect_reg != 2'd0, seen_reg < expect_reg,
                    "continuation count reached sequence length")
    `UDW_ASSERT_NEXT(a_eot_closes, accept && eot, expect_reg == 2'd0,
                     "sequence left open after end of text")
    `UDW_ASSERT_NOW(a_eot_yields, accept && eot, has_result,
                    "end of text produced no character")

endmodule

@@ tb/utf8_width_checker.sv @@
// ----------------------------------------------------------------------------
// UTF-8 width decoder checker
// Watches both channels, predicts the characters that each accepted byte
// yields and compares every result word field by field, oldest first.
// ----------------------------------------------------------------------------
module utf8_width_checker
    import utf8dw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        mismatches,
    output int        outstanding
);

    localparam longint SUM_TOP    = (longint'(1) << UDW_SUM_BITS) - 1;
    localparam int     MAX_CHARS  = 4;

    localparam logic [41:0] ZERO_SPANS [5] = '{
        {21'h00300, 21'h0036F}, {21'h0200B, 21'h0200F}, {21'h0FE00, 21'h0FE0F},
        {21'h0FEFF, 21'h0FEFF}, {21'h1F3FB, 21'h1F3FF}
    };

    localparam logic [41:0] WIDE_SPANS [36] = '{
        {21'h01100, 21'h0115F}, {21'h02329, 21'h0232A}, {21'h02460, 21'h024FF},
        {21'h02E80, 21'h0303E}, {21'h03041, 21'h033FF}, {21'h03400, 21'h04DBF},
        {21'h04E00, 21'h09FFF}, {21'h0A000, 21'h0A4CF}, {21'h0AC00, 21'h0D7A3},
        {21'h0F900, 21'h0FAFF}, {21'h0FE10, 21'h0FE19}, {21'h0FE30, 21'h0FE6F},
        {21'h0FF00, 21'h0FF60}, {21'h0FFE0, 21'h0FFE6}, {21'h1F300, 21'h1F64F},
        {21'h1F900, 21'h1F9FF}, {21'h20000, 21'h2FFFD}, {21'h30000, 21'h3FFFD},
        {21'h000B7, 21'h000B7}, {21'h02010, 21'h02016}, {21'h02018, 21'h02019},
        {21'h0201C, 21'h0201D}, {21'h02020, 21'h02027}, {21'h02030, 21'h02030},
        {21'h02032, 21'h02033}, {21'h02035, 21'h02035}, {21'h0203B, 21'h0203B},
        {21'h0203E, 21'h0203E}, {21'h02160, 21'h02179}, {21'h02190, 21'h02199},
        {21'h02260, 21'h02260}, {21'h02264, 21'h02265}, {21'h025A0, 21'h025FF},
        {21'h02605, 21'h02606}, {21'h02714, 21'h02714}, {21'h02718, 21'h02718}
    };

    out_word_t          expected_chars[$];
    logic [CP_BITS-1:0] seq_point;
    logic [1:0]         seq_need;
    logic [1:0]         seq_got;
    longint             col_sum;
    int                 step_chars;
    int                 word_index;

    function automatic logic [1:0] display_cols(input logic [CP_BITS-1:0] cp);
        foreach (ZERO_SPANS[k]) begin
            if (cp >= ZERO_SPANS[k][41:21] && cp <= ZERO_SPANS[k][20:0]) return COLS_ZERO;
        end
        foreach (WIDE_SPANS[k]) begin
            if (cp >= WIDE_SPANS[k][41:21] && cp <= WIDE_SPANS[k][20:0]) return COLS_TWO;
        end
        return COLS_ONE;
    endfunction

    task automatic emit_char(input logic [CP_BITS-1:0] cp, input logic bad,
                             input logic [2:0] count);
        out_word_t  w;
        logic [1:0] cols;
        if (step_chars >= MAX_CHARS) return;
        cols = bad ? COLS_ONE : display_cols(cp);
        col_sum += cols;
        if (col_sum > SUM_TOP) col_sum = SUM_TOP;
        w.code_point    = bad ? '0 : cp;
        w.invalid       = bad;
        w.byte_count    = bad ? 3'd1 : count;
        w.char_width    = cols;
        w.running_width = (col_sum > RW_MAX) ? RW_MAX : col_sum[RW_BITS-1:0];
        w.text_done     = 1'b0;
        expected_chars = {expected_chars, w};
        step_chars++;
    endtask

    task automatic clear_sequence();
        seq_need  = 2'd0;
        seq_got   = 2'd0;
        seq_point = '0;
    endtask

    task automatic drop_broken();
        emit_char('0, 1'b1, 3'd1);
        for (int k = 0; k < seq_got; k++) emit_char('0, 1'b1, 3'd1);
        clear_sequence();
    endtask

    task automatic open_char(input logic [7:0] b, input logic eot);
        logic [1:0]         need;
        logic [CP_BITS-1:0] bits;
        if (!b[7]) begin
            emit_char(CP_BITS'(b), 1'b0, 3'd1);
            return;
        end
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            need = 2'd1;
            bits = CP_BITS'(b & BITS2_MASK);
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            need = 2'd2;
            bits = CP_BITS'(b & BITS3_MASK);
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            need = 2'd3;
            bits = CP_BITS'(b & BITS4_MASK);
        end else begin
            emit_char('0, 1'b1, 3'd1);
            return;
        end
        if (eot) begin
            emit_char('0, 1'b1, 3'd1);
            return;
        end
        seq_need  = need;
        seq_got   = 2'd0;
        seq_point = bits;
    endtask

    task automatic predict_chars(input in_word_t w);
        out_word_t last;
        step_chars = 0;
        if (seq_need != 2'd0) begin
            if ((w.data_byte & CONT_MASK) == CONT_CODE) begin
                seq_point = {seq_point[CP_BITS-7:0], w.data_byte[5:0]};
                seq_got   = seq_got + 2'd1;
                if (seq_got >= seq_need) begin
                    emit_char(seq_point, 1'b0, {1'b0, seq_need} + 3'd1);
                    clear_sequence();
                end else if (w.end_of_text) begin
                    drop_broken();
                end
            end else begin
                drop_broken();
                open_char(w.data_byte, w.end_of_text);
            end
        end else begin
            open_char(w.data_byte, w.end_of_text);
        end
        if (w.end_of_text) begin
            if (step_chars > 0) begin
                last = expected_chars[expected_chars.size() - 1];
                last.text_done = 1'b1;
                expected_chars[expected_chars.size() - 1] = last;
            end
            col_sum = 0;
            clear_sequence();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("utf8 check: word %0d %s expected 0x%0h got 0x%0h",
                 word_index, field, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            expected_chars.delete();
            clear_sequence();
            col_sum    = 0;
            word_index = 0;
            mismatches = 0;
        end else begin
            if (s_valid && s_ready) predict_chars(s_data);
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("word with none expected, code_point", '0,
                                    m_data.code_point);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.code_point != want.code_point)
                        report_mismatch("code_point", want.code_point, m_data.code_point);
                    if (m_data.invalid != want.invalid)
                        report_mismatch("invalid", want.invalid, m_data.invalid);
                    if (m_data.byte_count != want.byte_count)
                        report_mismatch("byte_count", want.byte_count, m_data.byte_count);
                    if (m_data.char_width != want.char_width)
                        report_mismatch("char_width", want.char_width, m_data.char_width);
                    if (m_data.running_width != want.running_width)
                        report_mismatch("running_width", want.running_width,
                                        m_data.running_width);
                    if (m_data.text_done != want.text_done)
                        report_mismatch("text_done", want.text_done, m_data.text_done);
                end
                word_index++;
            end
        end
        outstanding <= expected_chars.size();
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// UTF-8 width decoder testbench
// Drives directed and random UTF-8 texts, well-formed and broken, with bursty
// input and a stalling receiver; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb
    import utf8dw_pkg::*;
();

    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_BYTES = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int EDGE_N       = 32;

    localparam logic [20:0] EDGE_POINTS [EDGE_N] = '{
        21'h000B6, 21'h000B7, 21'h002FF, 21'h00300, 21'h0036F, 21'h01100,
        21'h0115F, 21'h0200B, 21'h0200F, 21'h02010, 21'h02016, 21'h02329,
        21'h02E80, 21'h0303E, 21'h03041, 21'h04E00, 21'h09FFF, 21'h0AC00,
        21'h0D7A3, 21'h0FE0F, 21'h0FEFF, 21'h0FF60, 21'h0FFE6, 21'h1F3FB,
        21'h1F3FF, 21'h1F300, 21'h1F64F, 21'h1F9FF, 21'h2FFFD, 21'h3FFFD,
        21'h025A0, 21'h02714
    };

    typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_data;
    int         mismatches;
    int         outstanding;
    int         burst_left;
    int         bytes_sent;
    int         idle_cycles;
    bit         hold_req;
    logic [7:0] text_bytes[$];

    utf8_decode_display_width_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utf8_width_checker u_width_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, end_of_text: eot};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic add_byte(input logic [7:0] v);
        text_bytes = {text_bytes, v};
    endtask

    function automatic int char_len(input logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    task automatic append_char(input logic [20:0] cp, input int n);
        case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte(LEAD2_CODE | {3'b0, cp[10:6]});
                add_byte(CONT_CODE | {2'b0, cp[5:0]});
            end
            3: begin
                add_byte(LEAD3_CODE | {4'b0, cp[15:12]});
                add_byte(CONT_CODE | {2'b0, cp[11:6]});
                add_byte(CONT_CODE | {2'b0, cp[5:0]});
            end
            default: begin
                add_byte(LEAD4_CODE | {5'b0, cp[20:18]});
                add_byte(CONT_CODE | {2'b0, cp[17:12]});
                add_byte(CONT_CODE | {2'b0, cp[11:6]});
                add_byte(CONT_CODE | {2'b0, cp[5:0]});
            end
        endcase
    endtask

    task automatic append_random_char();
        int          pick;
        int          n;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            append_char(21'($urandom_range(0, 127)), 1);
        end else if (pick < 55) begin
            cp = 21'(EDGE_POINTS[$urandom_range(0, EDGE_N - 1)] + $urandom_range(0, 4) - 2);
            append_char(cp, char_len(cp));
        end else if (pick < 75) begin
            n  = $urandom_range(2, 4);
            cp = 21'($urandom());
            append_char(cp, n);
        end else if (pick < 85) begin
            if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range(128, 191)));
            else add_byte(8'($urandom_range(248, 255)));
        end else if (pick < 93) begin
            n  = $urandom_range(2, 4);
            cp = 21'($urandom());
            append_char(cp, n);
            repeat ($urandom_range(1, n - 1)) text_bytes.delete(text_bytes.size() - 1);
        end else begin
            add_byte(8'($urandom()));
        end
    endtask

    task automatic send_text();
        foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
    endtask

    initial begin
        s_valid    = 1'b0;
        s_data     = '0;
        aresetn    = 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        hold_req   = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        append_char(21'h00000, 1);
        append_char(21'h0007F, 1);
        append_char(21'h000B7, 2);
        append_char(21'h04E00, 3);
        append_char(21'h1F3FB, 4);
        append_char(21'h1FFFFF, 4);
        send_text();
        add_byte(8'h80);
        add_byte(8'hF8);
        send_text();
        // break a four-byte sequence after two continuations
        append_char(21'h1F3FB, 4);
        text_bytes.delete(text_bytes.size() - 1);
        add_byte(8'h41);
        send_text();
        // end the text one continuation short
        append_char(21'h04E00, 3);
        text_bytes.delete(text_bytes.size() - 1);
        send_text();
        add_byte(8'hC3);
        send_text();

        hold_req   = 1'b1;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 10)) append_random_char();
            send_text();
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        rx_mode_t mode;
        int       left;
        bit       hold_done;
        m_ready   = 1'b0;
        mode      = RX_OPEN;
        left      = 0;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(40, 120);
            end
            left--;
            case (mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
